>>> rtl/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg: shared types and constants for the quaternion vector rotator
// Holds the fixed-point formats and the derived widths of every pipeline
// stage so that all datapath sizes follow from the few base constants.
// ----------------------------------------------------------------------------
`default_nettype none

package qvr_pkg;

  // Base formats.
  localparam int QUAT_WIDTH     = 16;  // quaternion term width, signed
  localparam int QUAT_FRAC_BITS = 14;  // fraction bits of a quaternion term
  localparam int VEC_WIDTH      = 24;  // vector component width, signed

  // Raw product of two quaternion terms.
  localparam int PROD_W = 2 * QUAT_WIDTH;
  // Exact matrix entry with 2*QUAT_FRAC_BITS fraction bits: the larger of the
  // doubled-product range and the constant one, plus a bit for the add.
  localparam int FULL_BASE = (2 * QUAT_WIDTH > 2 * QUAT_FRAC_BITS) ?
                             2 * QUAT_WIDTH : 2 * QUAT_FRAC_BITS;
  localparam int FULL_W = FULL_BASE + 2;
  // Matrix entry rounded to QUAT_FRAC_BITS fraction bits.
  localparam int MAT_W = FULL_W - QUAT_FRAC_BITS;
  // Entry times vector component.
  localparam int MV_W = MAT_W + VEC_WIDTH;
  // Sum of three such products.
  localparam int ACC_W = MV_W + 2;
  // Rounded sum before saturation.
  localparam int SUM_W = ACC_W - QUAT_FRAC_BITS;

  typedef logic signed [QUAT_WIDTH-1:0] quat_t;
  typedef logic signed [VEC_WIDTH-1:0]  vec_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [FULL_W-1:0]     full_t;
  typedef logic signed [MAT_W-1:0]      mat_t;
  typedef logic signed [MV_W-1:0]       mv_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  // Direction select codes.
  localparam logic FUNC_BODY_TO_NAV = 1'b0;
  localparam logic FUNC_NAV_TO_BODY = 1'b1;

endpackage : qvr_pkg

`default_nettype wire

>>> rtl/quaternion_vector_rotator.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotator: rotate a 3-vector by a unit quaternion
// Builds the direction cosine matrix from doubled quaternion products and
// applies it (or its transpose) to the vector, with round-half-up fixed point
// and saturation of the result to the signed vector range.
//
//   Channel | Handshake            | Beat contents
//   --------+----------------------+--------------------------------------
//   in      | in_valid / in_ready  | in_func, in_quat_w/x/y/z, in_vec_x/y/z
//   out     | out_valid/out_ready  | out_x, out_y, out_z
//
// One beat is accepted per cycle while in_ready is high; each beat passes
// through five register stages (quaternion products, rounded
// matrix, entry-by-component products, rounded sums, saturated output).
// Reset clears the stage valid bits only; the datapath registers are not reset.
// A stalled output holds its beat; the ready chain lets the stages behind it
// keep filling any empty slot, so nothing is dropped or duplicated.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_vector_rotator (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_func,
  input  wire qvr_pkg::quat_t in_quat_w,
  input  wire qvr_pkg::quat_t in_quat_x,
  input  wire qvr_pkg::quat_t in_quat_y,
  input  wire qvr_pkg::quat_t in_quat_z,
  input  wire qvr_pkg::vec_t  in_vec_x,
  input  wire qvr_pkg::vec_t  in_vec_y,
  input  wire qvr_pkg::vec_t  in_vec_z,
  output logic               out_valid,
  input  wire logic          out_ready,
  output qvr_pkg::vec_t      out_x,
  output qvr_pkg::vec_t      out_y,
  output qvr_pkg::vec_t      out_z
);

  import qvr_pkg::*;

  localparam full_t ONE_FULL   = full_t'(1) <<< (2 * QUAT_FRAC_BITS);
  localparam full_t ROUND_FULL = full_t'(1) <<< (QUAT_FRAC_BITS - 1);
  localparam acc_t  ROUND_ACC  = acc_t'(1) <<< (QUAT_FRAC_BITS - 1);

  // Doubles a raw product and widens it to the exact entry format.
  function automatic full_t dbl_ext(input prod_t p);
    full_t e;
    e = {{(FULL_W - PROD_W){p[PROD_W-1]}}, p};
    return e <<< 1;
  endfunction

  // Rounds an exact entry to QUAT_FRAC_BITS fraction bits, half up.
  function automatic mat_t rnd_entry(input full_t f);
    full_t t;
    t = f + ROUND_FULL;
    return t[FULL_W-1:QUAT_FRAC_BITS];
  endfunction

  // Sign-extends one product to the accumulator width.
  function automatic acc_t acc_ext(input mv_t p);
    return {{(ACC_W - MV_W){p[MV_W-1]}}, p};
  endfunction

  // Stage valid bits and the ready chain.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage 1: the nine quaternion term products.
  prod_t xx1_r, yy1_r, zz1_r, xy1_r, yz1_r, xz1_r, wx1_r, wy1_r, wz1_r;
  logic  func1_r;
  vec_t  vec1_r [3];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      xx1_r     <= prod_t'(in_quat_x) * prod_t'(in_quat_x);
      yy1_r     <= prod_t'(in_quat_y) * prod_t'(in_quat_y);
      zz1_r     <= prod_t'(in_quat_z) * prod_t'(in_quat_z);
      xy1_r     <= prod_t'(in_quat_x) * prod_t'(in_quat_y);
      yz1_r     <= prod_t'(in_quat_y) * prod_t'(in_quat_z);
      xz1_r     <= prod_t'(in_quat_x) * prod_t'(in_quat_z);
      wx1_r     <= prod_t'(in_quat_w) * prod_t'(in_quat_x);
      wy1_r     <= prod_t'(in_quat_w) * prod_t'(in_quat_y);
      wz1_r     <= prod_t'(in_quat_w) * prod_t'(in_quat_z);
      func1_r   <= in_func;
      vec1_r[0] <= in_vec_x;
      vec1_r[1] <= in_vec_y;
      vec1_r[2] <= in_vec_z;
    end
  end

  // Stage 2: exact matrix entries, rounding, and the transpose select.
  full_t full_s2 [3][3];
  mat_t  mat_s2  [3][3];
  mat_t  coef_nxt [3][3];

  always_comb begin
    full_s2[0][0] = ONE_FULL - dbl_ext(yy1_r) - dbl_ext(zz1_r);
    full_s2[0][1] = dbl_ext(xy1_r) - dbl_ext(wz1_r);
    full_s2[0][2] = dbl_ext(xz1_r) + dbl_ext(wy1_r);
    full_s2[1][0] = dbl_ext(xy1_r) + dbl_ext(wz1_r);
    full_s2[1][1] = ONE_FULL - dbl_ext(xx1_r) - dbl_ext(zz1_r);
    full_s2[1][2] = dbl_ext(yz1_r) - dbl_ext(wx1_r);
    full_s2[2][0] = dbl_ext(xz1_r) - dbl_ext(wy1_r);
    full_s2[2][1] = dbl_ext(yz1_r) + dbl_ext(wx1_r);
    full_s2[2][2] = ONE_FULL - dbl_ext(xx1_r) - dbl_ext(yy1_r);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mat_s2[i][j] = rnd_entry(full_s2[i][j]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef_nxt[i][j] = (func1_r == FUNC_NAV_TO_BODY) ? mat_s2[j][i] : mat_s2[i][j];
      end
    end
  end

  mat_t coef2_r [3][3];
  vec_t vec2_r  [3];

  always_ff @(posedge clk) begin
    if (rdy2) begin
      coef2_r <= coef_nxt;
      vec2_r  <= vec1_r;
    end
  end

  // Stage 3: each coefficient times its vector component.
  mv_t mv3_r [3][3];

  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mv3_r[i][j] <= mv_t'(coef2_r[i][j]) * mv_t'(vec2_r[j]);
        end
      end
    end
  end

  // Stage 4: row sums rounded to integers, half up.
  acc_t acc_s4  [3];
  sum_t sum_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_s4[i]  = acc_ext(mv3_r[i][0]) + acc_ext(mv3_r[i][1]) + acc_ext(mv3_r[i][2]) +
                   ROUND_ACC;
      sum_nxt[i] = acc_s4[i][ACC_W-1:QUAT_FRAC_BITS];
    end
  end

  sum_t sum4_r [3];

  always_ff @(posedge clk) begin
    if (rdy4) begin
      sum4_r <= sum_nxt;
    end
  end

  // Stage 5: clamp to the signed vector range.
  vec_t sat_nxt [3];
  logic [SUM_W-VEC_WIDTH:0] hi_bits [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hi_bits[i] = sum4_r[i][SUM_W-1:VEC_WIDTH-1];
      if ((&hi_bits[i]) || !(|hi_bits[i])) begin
        sat_nxt[i] = sum4_r[i][VEC_WIDTH-1:0];
      end else if (sum4_r[i][SUM_W-1]) begin
        sat_nxt[i] = {1'b1, {(VEC_WIDTH - 1){1'b0}}};
      end else begin
        sat_nxt[i] = {1'b0, {(VEC_WIDTH - 1){1'b1}}};
      end
    end
  end

  vec_t out5_r [3];

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out5_r <= sat_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_x     = out5_r[0];
  assign out_y     = out5_r[1];
  assign out_z     = out5_r[2];

`ifndef SYNTHESIS
  // An accepted input beat always lands in the first stage.
  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted input beat missing from stage 1");

  // With every stage full and the output stalled, no new beat is taken.
  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && v4_r && v5_r && !out_ready) |-> !in_ready)
    else $error("input accepted while pipeline full and stalled");

  // A beat in stage 4 moves to the output whenever the output slot frees.
  a_s4_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && (!v5_r || out_ready)) |=> out_valid)
    else $error("stage 4 beat lost on its way to the output");

  // A stalled output beat is never overwritten by the stage behind it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out5_r[0]) &&
                                   $stable(out5_r[1]) && $stable(out5_r[2])))
    else $error("stalled output beat changed");
`endif

endmodule : quaternion_vector_rotator

`default_nettype wire
